// File: rtl/core/gene_crossover_mutation_core_defines.svh
// Assertion macros shared by the gene crossover and mutation core.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GENE_CROSSOVER_MUTATION_CORE_DEFINES_SVH
`define GENE_CROSSOVER_MUTATION_CORE_DEFINES_SVH

// Plain property, checked out of reset.
`define GCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a check in the next.
`define GCM_ASSERT_NEXT(label, cond, nxt, msg) \
    `GCM_ASSERT(label, (cond) |=> (nxt), msg)

`endif

// File: rtl/core/gcm_pkg.sv
// Package for the gene crossover and mutation core: widths, config codes,
// payload structs and the reciprocal table for the noise-sum divide.
package gcm_pkg;

    localparam int GENE_BITS     = 32;
    localparam int DRAW_BITS     = 16;
    localparam int DEV_FRAC      = 16;
    localparam int RANGE_BITS    = 31;
    localparam int NSUM_BITS     = 20;
    localparam int THRESH_BITS   = 17;
    localparam int DEV_BITS      = 24;
    localparam int CNT_BITS      = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // Reciprocal: ceil(2^RECIP_SHIFT / n), exact for every noise sum and count.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int QPROD_BITS  = NSUM_BITS + RECIP_BITS;

    localparam int NOISE_BITS       = NSUM_BITS + 1;
    localparam int SPREAD_PROD_BITS = NOISE_BITS + DEV_BITS + 1;
    localparam int SPREAD_BITS      = SPREAD_PROD_BITS - DRAW_BITS;
    localparam int DELTA_PROD_BITS  = SPREAD_BITS + RANGE_BITS + 1;
    localparam int DELTA_BITS       = DELTA_PROD_BITS - DEV_FRAC;
    localparam int SUM_BITS         = DELTA_BITS + 1;

    localparam logic signed [NOISE_BITS-1:0] NOISE_CENTER = NOISE_BITS'(1 << (DRAW_BITS - 1));

    localparam logic [CFG_IDX_BITS-1:0] CFG_CROSS_TH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MUT_TH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVIATION = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE_CNT = 2'd3;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = '0;
    localparam logic [DEV_BITS-1:0]    DEV_RESET    = 24'd65536;
    localparam logic [CNT_BITS-1:0]    CNT_RESET    = 5'd12;

    typedef struct packed {
        logic signed [GENE_BITS-1:0] parent_gene;
        logic signed [GENE_BITS-1:0] partner_gene;
        logic signed [GENE_BITS-1:0] upper_bound;
        logic signed [GENE_BITS-1:0] lower_bound;
        logic [RANGE_BITS-1:0]       gene_range;
        logic [DRAW_BITS-1:0]        crossover_draw;
        logic [DRAW_BITS-1:0]        mutation_draw;
        logic [NSUM_BITS-1:0]        noise_sum;
    } t_gcm_in;

    typedef struct packed {
        logic signed [GENE_BITS-1:0] child_gene;
        logic                        crossed;
        logic                        mutated;
    } t_gcm_out;

    typedef struct packed {
        logic [THRESH_BITS-1:0] crossover_threshold;
        logic [THRESH_BITS-1:0] mutation_threshold;
        logic [DEV_BITS-1:0]    deviation;
        logic [CNT_BITS-1:0]    noise_count;
    } t_gcm_cfg;

    // Per-gene data that rides alongside the noise arithmetic.
    typedef struct packed {
        logic signed [GENE_BITS-1:0] child_gene;
        logic signed [GENE_BITS-1:0] upper_bound;
        logic signed [GENE_BITS-1:0] lower_bound;
        logic [RANGE_BITS-1:0]       gene_range;
        logic                        crossed;
        logic                        mutated;
    } t_gcm_side;

    typedef struct packed {
        logic [NSUM_BITS-1:0]  nsum;
        logic [RECIP_BITS-1:0] recip;
    } t_gcm_div;

    // Count zero behaves as one.
    function automatic logic [RECIP_BITS-1:0] recip_lookup(input logic [CNT_BITS-1:0] cnt);
        logic [RECIP_BITS-1:0] r;
        case (cnt)
            5'd2:    r = 27'd33554432;
            5'd3:    r = 27'd22369622;
            5'd4:    r = 27'd16777216;
            5'd5:    r = 27'd13421773;
            5'd6:    r = 27'd11184811;
            5'd7:    r = 27'd9586981;
            5'd8:    r = 27'd8388608;
            5'd9:    r = 27'd7456541;
            5'd10:   r = 27'd6710887;
            5'd11:   r = 27'd6100806;
            5'd12:   r = 27'd5592406;
            5'd13:   r = 27'd5162221;
            5'd14:   r = 27'd4793491;
            5'd15:   r = 27'd4473925;
            5'd16:   r = 27'd4194304;
            5'd17:   r = 27'd3947581;
            5'd18:   r = 27'd3728271;
            5'd19:   r = 27'd3532046;
            5'd20:   r = 27'd3355444;
            5'd21:   r = 27'd3195661;
            5'd22:   r = 27'd3050403;
            5'd23:   r = 27'd2917777;
            5'd24:   r = 27'd2796203;
            5'd25:   r = 27'd2684355;
            5'd26:   r = 27'd2581111;
            5'd27:   r = 27'd2485514;
            5'd28:   r = 27'd2396746;
            5'd29:   r = 27'd2314099;
            5'd30:   r = 27'd2236963;
            5'd31:   r = 27'd2164803;
            default: r = 27'd67108864;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/gcm_decide.sv
// First pipeline stage: crossover and mutation decisions, parent mean,
// reciprocal lookup for the noise divide. Depends on gcm_pkg.
`include "gene_crossover_mutation_core_defines.svh"

module gcm_decide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcm_pkg::t_gcm_cfg i_cfg,
    input  logic              i_valid,
    input  gcm_pkg::t_gcm_in  i_data,
    output logic              o_stall,
    output logic              o_valid,
    output gcm_pkg::t_gcm_side o_side,
    output gcm_pkg::t_gcm_div o_div,
    input  logic              i_stall
);
    import gcm_pkg::*;

    logic                        w_en;
    logic                        r_vld;
    logic                        n_vld;
    logic signed [GENE_BITS:0]   w_pair_sum;
    t_gcm_side                   n_side;
    t_gcm_side                   r_side;
    t_gcm_div                    n_div;
    t_gcm_div                    r_div;

    assign w_en = !r_vld || !i_stall;
    assign n_vld = w_en ? i_valid : r_vld;

    always_comb begin
        w_pair_sum = (GENE_BITS + 1)'(i_data.parent_gene) + (GENE_BITS + 1)'(i_data.partner_gene);
        n_side.crossed = {1'b0, i_data.crossover_draw} < i_cfg.crossover_threshold;
        n_side.mutated = {1'b0, i_data.mutation_draw} < i_cfg.mutation_threshold;
        // floor of the mean: arithmetic shift of the full-width sum
        n_side.child_gene  = n_side.crossed ? w_pair_sum[GENE_BITS:1] : i_data.parent_gene;
        n_side.upper_bound = i_data.upper_bound;
        n_side.lower_bound = i_data.lower_bound;
        n_side.gene_range  = i_data.gene_range;
        n_div.nsum  = i_data.noise_sum;
        n_div.recip = recip_lookup(i_cfg.noise_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
            r_div  <= n_div;
        end
    end

    assign o_stall = !w_en;
    assign o_valid = r_vld;
    assign o_side  = r_side;
    assign o_div   = r_div;

    `GCM_ASSERT_NEXT(a_cross_flag, i_valid && w_en,
        r_side.crossed == ($past(i_data.crossover_draw) < $past(i_cfg.crossover_threshold)),
        "crossed flag does not match draw against threshold")

endmodule

// File: rtl/core/gcm_noise.sv
// Noise stages: divide the noise sum by the count through a reciprocal
// multiply, center it, scale by deviation. Three register stages. Depends on gcm_pkg.
`include "gene_crossover_mutation_core_defines.svh"

module gcm_noise (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcm_pkg::t_gcm_cfg  i_cfg,
    input  logic               i_valid,
    input  gcm_pkg::t_gcm_side i_side,
    input  gcm_pkg::t_gcm_div  i_div,
    output logic               o_stall,
    output logic               o_valid,
    output gcm_pkg::t_gcm_side o_side,
    output logic signed [gcm_pkg::SPREAD_PROD_BITS-1:0] o_spread_prod,
    input  logic               i_stall
);
    import gcm_pkg::*;

    localparam int STAGES = 3;

    logic [STAGES-1:0]               w_en;
    logic [STAGES-1:0]               r_vld;
    logic [STAGES-1:0]               n_vld;
    t_gcm_side                       r_side [STAGES];
    logic [QPROD_BITS-1:0]           r_quot_prod;
    logic [NSUM_BITS-1:0]            w_quot;
    logic signed [NOISE_BITS-1:0]    r_noise;
    logic signed [SPREAD_PROD_BITS-1:0] r_spread_prod;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // quotient fits the noise-sum width since the count is at least one
    assign w_quot = r_quot_prod[RECIP_SHIFT +: NSUM_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_quot_prod <= QPROD_BITS'(i_div.nsum) * QPROD_BITS'(i_div.recip);
            r_side[0]   <= i_side;
        end
        if (w_en[1]) begin
            r_noise   <= $signed({1'b0, w_quot}) - NOISE_CENTER;
            r_side[1] <= r_side[0];
        end
        if (w_en[2]) begin
            r_spread_prod <= SPREAD_PROD_BITS'(r_noise) * SPREAD_PROD_BITS'($signed({1'b0, i_cfg.deviation}));
            r_side[2]     <= r_side[1];
        end
    end

    assign o_stall       = !w_en[0];
    assign o_valid       = r_vld[STAGES-1];
    assign o_side        = r_side[STAGES-1];
    assign o_spread_prod = r_spread_prod;

    `GCM_ASSERT_NEXT(a_spread_hold, r_vld[STAGES-1] && i_stall,
        $stable(r_spread_prod) && $stable(r_side[STAGES-1]),
        "spread product changed while held")

endmodule

// File: rtl/core/gcm_delta.sv
// Delta stages: scale the spread by the gene range, add to the child gene,
// clamp to the bounds for mutated genes and register the result beat. Depends on gcm_pkg.
`include "gene_crossover_mutation_core_defines.svh"

module gcm_delta (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  gcm_pkg::t_gcm_side i_side,
    input  logic signed [gcm_pkg::SPREAD_PROD_BITS-1:0] i_spread_prod,
    output logic               o_stall,
    output logic               o_valid,
    output gcm_pkg::t_gcm_out  o_data,
    input  logic               i_stall
);
    import gcm_pkg::*;

    localparam int STAGES = 3;

    logic [STAGES-1:0]                 w_en;
    logic [STAGES-1:0]                 r_vld;
    logic [STAGES-1:0]                 n_vld;
    t_gcm_side                         r_side [STAGES-1];
    logic signed [SPREAD_BITS-1:0]     w_spread;
    logic signed [DELTA_PROD_BITS-1:0] r_delta_prod;
    logic signed [DELTA_BITS-1:0]      w_delta;
    logic signed [SUM_BITS-1:0]        r_sum;
    logic signed [SUM_BITS-1:0]        w_upper;
    logic signed [SUM_BITS-1:0]        w_lower;
    t_gcm_out                          n_out;
    t_gcm_out                          r_out;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // floor shifts: keep the high bits of the signed products
    assign w_spread = $signed(i_spread_prod[SPREAD_PROD_BITS-1:DRAW_BITS]);
    assign w_delta  = $signed(r_delta_prod[DELTA_PROD_BITS-1:DEV_FRAC]);
    assign w_upper  = SUM_BITS'(r_side[1].upper_bound);
    assign w_lower  = SUM_BITS'(r_side[1].lower_bound);

    always_comb begin
        n_out.crossed = r_side[1].crossed;
        n_out.mutated = r_side[1].mutated;
        if (!r_side[1].mutated) begin
            n_out.child_gene = r_side[1].child_gene;
        end else if (r_sum > w_upper) begin
            n_out.child_gene = r_side[1].upper_bound;
        end else if (r_sum < w_lower) begin
            n_out.child_gene = r_side[1].lower_bound;
        end else begin
            n_out.child_gene = r_sum[GENE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_delta_prod <= DELTA_PROD_BITS'(w_spread) * DELTA_PROD_BITS'($signed({1'b0, i_side.gene_range}));
            r_side[0]    <= i_side;
        end
        if (w_en[1]) begin
            r_sum     <= SUM_BITS'(r_side[0].child_gene) + SUM_BITS'(w_delta);
            r_side[1] <= r_side[0];
        end
        if (w_en[2]) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_data  = r_out;

    `GCM_ASSERT_NEXT(a_clamp_in_bounds,
        w_en[2] && r_vld[1] && r_side[1].mutated
            && (r_side[1].lower_bound <= r_side[1].upper_bound),
        (r_out.child_gene <= $past(r_side[1].upper_bound))
            && (r_out.child_gene >= $past(r_side[1].lower_bound)),
        "mutated child outside ordered bounds")

    `GCM_ASSERT_NEXT(a_no_mutate_pass, w_en[2] && r_vld[1] && !r_side[1].mutated,
        r_out.child_gene == $past(r_side[1].child_gene),
        "unmutated child altered by clamp stage")

endmodule

// File: rtl/core/gene_crossover_mutation_core.sv
// Top level of the gene crossover and mutation core: configuration registers
// and the seven-stage pipeline. Depends on gcm_pkg, gcm_decide, gcm_noise, gcm_delta.

// One gene per beat, one beat per cycle sustained while i_stall is low. Each
// stage holds its own valid bit and only stalls when its successor is full,
// so bubbles close up under back pressure. The stages split the work around
// the three multipliers: noise sum times count reciprocal, centered noise
// times deviation, spread times gene range; the last two stages add the
// delta and clamp. Write the configuration registers only while no beat is
// in flight.
module gene_crossover_mutation_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gcm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gcm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                i_valid,
    input  gcm_pkg::t_gcm_in                    i_data,
    output logic                                o_stall,
    output logic                                o_valid,
    output gcm_pkg::t_gcm_out                   o_data,
    input  logic                                i_stall
);
    import gcm_pkg::*;

    t_gcm_cfg  r_cfg;
    logic      w_s1_valid;
    logic      w_s1_stall;
    t_gcm_side w_s1_side;
    t_gcm_div  w_s1_div;
    logic      w_s4_valid;
    logic      w_s4_stall;
    t_gcm_side w_s4_side;
    logic signed [SPREAD_PROD_BITS-1:0] w_s4_spread;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crossover_threshold <= THRESH_RESET;
            r_cfg.mutation_threshold  <= THRESH_RESET;
            r_cfg.deviation           <= DEV_RESET;
            r_cfg.noise_count         <= CNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CROSS_TH:  r_cfg.crossover_threshold <= i_cfg_wdata[THRESH_BITS-1:0];
                CFG_MUT_TH:    r_cfg.mutation_threshold  <= i_cfg_wdata[THRESH_BITS-1:0];
                CFG_DEVIATION: r_cfg.deviation           <= i_cfg_wdata[DEV_BITS-1:0];
                CFG_NOISE_CNT: r_cfg.noise_count         <= i_cfg_wdata[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    gcm_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (w_s1_valid),
        .o_side  (w_s1_side),
        .o_div   (w_s1_div),
        .i_stall (w_s1_stall)
    );

    gcm_noise u_noise (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (w_s1_valid),
        .i_side        (w_s1_side),
        .i_div         (w_s1_div),
        .o_stall       (w_s1_stall),
        .o_valid       (w_s4_valid),
        .o_side        (w_s4_side),
        .o_spread_prod (w_s4_spread),
        .i_stall       (w_s4_stall)
    );

    gcm_delta u_delta (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s4_valid),
        .i_side        (w_s4_side),
        .i_spread_prod (w_s4_spread),
        .o_stall       (w_s4_stall),
        .o_valid       (o_valid),
        .o_data        (o_data),
        .i_stall       (i_stall)
    );

endmodule

// File: bench/gene_crossover_mutation_core_test.sv
// Self-checking bench for gene_crossover_mutation_core: random and directed genes
// against a local child-gene predictor, under random and long output stalls.
// Depends on gcm_pkg and the core RTL only.
module gene_crossover_mutation_core_test;
    import gcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;   // pipeline is seven deep
    localparam int HOLD_CYCLES    = 80;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_GENES    = 142;

    localparam logic signed [GENE_BITS-1:0] G_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [GENE_BITS-1:0] G_MIN = 32'sh8000_0000;
    localparam logic [RANGE_BITS-1:0]       R_MAX = 31'h7FFF_FFFF;
    localparam logic [NSUM_BITS-1:0]        NS_MAX = 20'hF_FFFF;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     i_valid = 1'b0;
    t_gcm_in                  i_data = '0;
    logic                     o_stall;
    logic                     o_valid;
    t_gcm_out                 o_data;
    logic                     i_stall = 1'b0;

    gene_crossover_mutation_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    always #4 i_clk = ~i_clk;

    // register mirror
    logic [THRESH_BITS-1:0] cross_th   = THRESH_RESET;
    logic [THRESH_BITS-1:0] mut_th     = THRESH_RESET;
    logic [DEV_BITS-1:0]    spread_dev = DEV_RESET;
    logic [CNT_BITS-1:0]    draw_count = CNT_RESET;

    t_gcm_in  gene_q[$];
    t_gcm_out child_q[$];

    int  total_queued = 0;
    int  results_seen = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    int  n_crossed = 0;
    int  n_mutated = 0;
    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;

    // fixed settings first: extremes, threshold above one, zero and large counts
    logic [CFG_DATA_BITS-1:0] ct_tab  [6] = '{65536, 131071, 0, 32768, 65535, 1};
    logic [CFG_DATA_BITS-1:0] mt_tab  [6] = '{65536, 32768, 65535, 131071, 65536, 1};
    logic [CFG_DATA_BITS-1:0] dev_tab [6] = '{65536, 24'hFF_FFFF, 0, 200000, 65536, 24'hFF_FFFF};
    logic [CFG_DATA_BITS-1:0] cnt_tab [6] = '{12, 31, 1, 16, 0, 17};

    function automatic t_gcm_out breed_gene(input t_gcm_in g);
        longint   child, upper, lower, rng, cnt, c, s, d, x;
        t_gcm_out r;
        child = longint'($signed(g.parent_gene));
        upper = longint'($signed(g.upper_bound));
        lower = longint'($signed(g.lower_bound));
        rng   = longint'(g.gene_range);
        r = '0;
        if ({1'b0, g.crossover_draw} < cross_th) begin
            child = (child + longint'($signed(g.partner_gene))) >>> 1;
            r.crossed = 1'b1;
        end
        if ({1'b0, g.mutation_draw} < mut_th) begin
            cnt = (draw_count == 0) ? 1 : longint'(draw_count);
            c = longint'(g.noise_sum) / cnt - 32768;
            s = (c * longint'(spread_dev)) >>> DRAW_BITS;
            d = (s * rng) >>> DEV_FRAC;
            x = child + d;
            if (x > upper)
                child = upper;
            else if (x < lower)
                child = lower;
            else
                child = x;
            r.mutated = 1'b1;
        end
        r.child_gene = child[GENE_BITS-1:0];
        return r;
    endfunction

    function automatic t_gcm_in gene(input logic [31:0] p, q, hi, lo, input logic [30:0] rng,
                                     input logic [15:0] cd, md, input logic [19:0] ns);
        t_gcm_in g;
        g.parent_gene    = p;
        g.partner_gene   = q;
        g.upper_bound    = hi;
        g.lower_bound    = lo;
        g.gene_range     = rng;
        g.crossover_draw = cd;
        g.mutation_draw  = md;
        g.noise_sum      = ns;
        return g;
    endfunction

    // tidy genes sit inside their bounds with a matching range and a plausible noise sum
    function automatic t_gcm_in make_gene(input bit tidy);
        t_gcm_in g;
        longint  lo, hi, span, nsum;
        int      cnt;
        if (!tidy)
            return gene($urandom, $urandom, $urandom, $urandom, RANGE_BITS'($urandom),
                        DRAW_BITS'($urandom_range(0, 65535)),
                        DRAW_BITS'($urandom_range(0, 65535)),
                        NSUM_BITS'($urandom_range(0, NS_MAX)));
        span = ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                           : longint'($urandom_range(0, 32'h00FF_FFFF));
        lo = longint'($signed($urandom));
        hi = lo + span;
        if (hi > 64'sd2147483647) begin
            hi = 64'sd2147483647;
            lo = hi - span;
        end
        cnt = (draw_count == 0) ? 1 : int'(draw_count);
        nsum = 0;
        for (int k = 0; k < cnt; k++)
            nsum += longint'($urandom_range(0, 65535));
        if (nsum > longint'(NS_MAX))
            nsum = longint'(NS_MAX);
        g.parent_gene    = 32'(lo + longint'($urandom) % (span + 1));
        g.partner_gene   = 32'(lo + longint'($urandom) % (span + 1));
        g.upper_bound    = 32'(hi);
        g.lower_bound    = 32'(lo);
        g.gene_range     = (span > longint'(R_MAX)) ? R_MAX : 31'(span);
        g.crossover_draw = DRAW_BITS'($urandom_range(0, 65535));
        g.mutation_draw  = DRAW_BITS'($urandom_range(0, 65535));
        g.noise_sum      = 20'(nsum);
        return g;
    endfunction

    task automatic offer(input t_gcm_in g);
        gene_q.push_back(g);
        total_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_CROSS_TH:  cross_th   = val[THRESH_BITS-1:0];
            CFG_MUT_TH:    mut_th     = val[THRESH_BITS-1:0];
            CFG_DEVIATION: spread_dev = val[DEV_BITS-1:0];
            CFG_NOISE_CNT: draw_count = val[CNT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] ct, mt, dev, cnt);
        write_reg(CFG_CROSS_TH, ct);
        write_reg(CFG_MUT_TH, mt);
        write_reg(CFG_DEVIATION, dev);
        write_reg(CFG_NOISE_CNT, cnt);
    endtask

    // every gene yields one child, so done means all children seen
    task automatic drain();
        while (results_seen != total_queued)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (gene_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                i_valid <= 1'b1;
                i_data  <= gene_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back pressure, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_gap_pct);
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        t_gcm_out want;
        bit       out_taken;
        if (i_rst_n) begin
            in_taken  = i_valid && !o_stall;
            out_taken = o_valid && !i_stall;
            if (in_taken)
                child_q.push_back(breed_gene(i_data));
            if (out_taken) begin
                results_seen++;
                if (child_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat: expected none, got child %0d crossed %0b mutated %0b",
                             $time, o_data.child_gene, o_data.crossed, o_data.mutated);
                end else begin
                    want = child_q.pop_front();
                    n_crossed += int'(want.crossed);
                    n_mutated += int'(want.mutated);
                    if (o_data.child_gene !== want.child_gene) begin
                        errors++;
                        $display("%0t child_gene mismatch: expected %0d, got %0d",
                                 $time, want.child_gene, o_data.child_gene);
                    end
                    if (o_data.crossed !== want.crossed) begin
                        errors++;
                        $display("%0t crossed mismatch: expected %0b, got %0b",
                                 $time, want.crossed, o_data.crossed);
                    end
                    if (o_data.mutated !== want.mutated) begin
                        errors++;
                        $display("%0t mutated mismatch: expected %0b, got %0b",
                                 $time, want.mutated, o_data.mutated);
                    end
                end
            end
            if (in_taken || out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles, %0d of %0d children seen",
                         $time, quiet_cycles, results_seen, total_queued);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 25;
        recv_gap_pct = 46;

        // reset settings: neither crossover nor mutation
        for (int k = 0; k < 3; k++)
            offer(make_gene(1'b1));
        drain();

        // always cross and mutate, neutral spread, twelve draws (center 393216)
        set_regs(65536, 65536, 65536, 12);
        offer(gene(G_MAX, G_MAX, G_MAX, G_MIN, 0, 0, 0, 393216));
        offer(gene(G_MIN, G_MIN, G_MAX, G_MIN, R_MAX, 65535, 65535, 393216));
        offer(gene(G_MAX, G_MIN, G_MAX, G_MIN, R_MAX, 0, 0, 0));
        offer(gene(-1, 0, G_MAX, G_MIN, 65536, 0, 0, NS_MAX));
        // bounds given the wrong way round
        offer(gene(0, 0, -(100 << 16), 100 << 16, 0, 0, 0, 393216));
        offer(gene(-(10 << 16), -(10 << 16), -(5 << 16), 5 << 16, 0, 0, 0, 393216));
        // landing exactly on a bound
        offer(gene(7 << 16, 7 << 16, 7 << 16, -(7 << 16), 0, 0, 0, 393216));
        offer(gene(-(7 << 16), -(7 << 16), 7 << 16, -(7 << 16), 0, 0, 0, 393216));
        // noise pushes past a bound
        offer(gene(0, 0, 1 << 16, -(1 << 16), 10 << 16, 0, 0, 0));
        offer(gene(0, 0, 1 << 16, -(1 << 16), 10 << 16, 65535, 65535, NS_MAX));
        drain();

        // half rates, widest spread, zero count read as one
        set_regs(32768, 32768, 24'hFF_FFFF, 0);
        offer(gene(G_MAX, G_MIN, G_MAX, G_MIN, R_MAX, 32767, 32767, NS_MAX));
        offer(gene(12345, -999, G_MAX, G_MIN, R_MAX, 32768, 32768, NS_MAX));
        offer(gene(-3, 8, G_MAX, G_MIN, R_MAX, 32767, 32768, 0));
        offer(gene(G_MIN, G_MAX, G_MAX, G_MIN, R_MAX, 32768, 32767, 0));
        offer(gene(1 << 16, 3 << 16, G_MAX, G_MIN, 1, 0, 0, 1));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            send_gap_pct = (ph < 4) ? 25 : (ph < 8) ? 46 : 0;
            recv_gap_pct = (ph < 4) ? 46 : (ph < 8) ? 25 : 0;
            if (ph < 6)
                set_regs(ct_tab[ph], mt_tab[ph], dev_tab[ph], cnt_tab[ph]);
            else
                set_regs(CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(0, 65536)
                                                              : $urandom_range(0, 24'hFF_FFFF)),
                         CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(0, 65536)
                                                              : $urandom_range(0, 24'hFF_FFFF)),
                         CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF)),
                         CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF)));
            if (ph == 8)
                hold_req = 1'b1;   // long output hold while the sender keeps pushing
            for (int k = 0; k < PHASE_GENES; k++)
                offer(make_gene($urandom_range(0, 99) < 75));
            drain();
        end

        $display("Ran %0d genes over %0d register settings with random and long output stalls;",
                 results_seen, RAND_PHASES + 3);
        $display("%0d children were averaged and %0d mutated and clamped.", n_crossed, n_mutated);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
